// ----- hw/rtl/qrm_pkg.sv -----
package qrm_pkg;

   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 14;

   // Component positions inside every quaternion array.
   localparam int IDX_X = 0;
   localparam int IDX_Y = 1;
   localparam int IDX_Z = 2;
   localparam int IDX_W = 3;

   typedef enum logic {
      OP_PRODUCT = 1'b0,
      OP_ROTATE  = 1'b1
   } op_type;

   // Width of a rounded doubled product, including the rounding constant.
   function automatic int t_width(int d, int f);
      return ((2 * d > f) ? 2 * d : f) + 1;
   endfunction

   // Width of a rotation matrix entry: one minus two doubled products.
   function automatic int m_width(int d, int f);
      return ((t_width(d, f) > f + 2) ? t_width(d, f) : f + 2) + 2;
   endfunction

   // Width of an unrounded result component.
   function automatic int a_width(int d, int f);
      return m_width(d, f) + d + 2;
   endfunction

endpackage

// ----- hw/rtl/qrm_mul.sv -----
module qrm_mul #(
   parameter int DATA_WIDTH = qrm_pkg::DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  qrm_pkg::op_type              in_op,
   input  logic signed [DATA_WIDTH-1:0] in_a [4],
   input  logic signed [DATA_WIDTH-1:0] in_b [4],
   output logic                         out_valid,
   input  logic                         out_ready,
   output qrm_pkg::op_type              out_op,
   output logic signed [DATA_WIDTH-1:0] out_bv [3],
   output logic signed [2*DATA_WIDTH-1:0] out_prod [4][4]
);

   logic                           valid_ff, valid_in;
   logic                           load;
   qrm_pkg::op_type                op_ff, op_in;
   logic signed [DATA_WIDTH-1:0]   bv_ff [3];
   logic signed [DATA_WIDTH-1:0]   bv_in [3];
   logic signed [2*DATA_WIDTH-1:0] prod_ff [4][4];
   logic signed [2*DATA_WIDTH-1:0] prod_in [4][4];
   logic signed [DATA_WIDTH-1:0]   sel [4];

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // For a rotation the second operand is a itself, which yields every
   // component product the matrix terms need.
   always_comb begin
      op_in = in_op;
      for (int i = 0; i < 4; i++) begin
         sel[i] = (in_op == qrm_pkg::OP_ROTATE) ? in_a[i] : in_b[i];
      end
      for (int i = 0; i < 3; i++) begin
         bv_in[i] = in_b[i];
      end
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            prod_in[i][j] = in_a[i] * sel[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff   <= op_in;
         bv_ff   <= bv_in;
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_op    = op_ff;
   assign out_bv    = bv_ff;
   assign out_prod  = prod_ff;

endmodule

// ----- hw/rtl/qrm_matrix.sv -----
module qrm_matrix #(
   parameter int DATA_WIDTH = qrm_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = qrm_pkg::FRAC_BITS_DEF,
   localparam int WM = qrm_pkg::m_width(DATA_WIDTH, FRAC_BITS),
   localparam int WQ = 2 * DATA_WIDTH + 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  qrm_pkg::op_type                in_op,
   input  logic signed [DATA_WIDTH-1:0]   in_bv [3],
   input  logic signed [2*DATA_WIDTH-1:0] in_prod [4][4],
   output logic                           out_valid,
   input  logic                           out_ready,
   output qrm_pkg::op_type                out_op,
   output logic signed [DATA_WIDTH-1:0]   out_bv [3],
   output logic signed [WM-1:0]           out_m [3][3],
   output logic signed [WQ-1:0]           out_q [4]
);

   localparam int WT = qrm_pkg::t_width(DATA_WIDTH, FRAC_BITS);
   localparam int X  = qrm_pkg::IDX_X;
   localparam int Y  = qrm_pkg::IDX_Y;
   localparam int Z  = qrm_pkg::IDX_Z;
   localparam int W  = qrm_pkg::IDX_W;

   localparam logic signed [WT-1:0] HALF_T = WT'(1) << (FRAC_BITS - 2);
   localparam logic signed [WM-1:0] ONE_M  = WM'(1) << FRAC_BITS;

   logic                         valid_ff, valid_in;
   logic                         load;
   qrm_pkg::op_type              op_ff, op_in;
   logic signed [DATA_WIDTH-1:0] bv_ff [3];
   logic signed [DATA_WIDTH-1:0] bv_in [3];
   logic signed [WM-1:0]         m_ff [3][3];
   logic signed [WM-1:0]         m_in [3][3];
   logic signed [WQ-1:0]         q_ff [4];
   logic signed [WQ-1:0]         q_in [4];
   logic signed [WT-1:0]         t [4][4];
   logic signed [WM-1:0]         te [4][4];
   logic signed [WQ-1:0]         pe [4][4];

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      op_in = in_op;
      bv_in = in_bv;
      // Doubled products rounded to the fraction width.
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            t[i][j]  = (WT'(in_prod[i][j]) + HALF_T) >>> (FRAC_BITS - 1);
            te[i][j] = WM'(t[i][j]);
            pe[i][j] = WQ'(in_prod[i][j]);
         end
      end

      m_in[0][0] = ONE_M - (te[Y][Y] + te[Z][Z]);
      m_in[0][1] = te[X][Y] - te[W][Z];
      m_in[0][2] = te[X][Z] + te[W][Y];
      m_in[1][0] = te[X][Y] + te[W][Z];
      m_in[1][1] = ONE_M - (te[X][X] + te[Z][Z]);
      m_in[1][2] = te[Y][Z] - te[W][X];
      m_in[2][0] = te[X][Z] - te[W][Y];
      m_in[2][1] = te[Y][Z] + te[W][X];
      m_in[2][2] = ONE_M - (te[X][X] + te[Y][Y]);

      // Hamilton product sums; the first index is the component of a.
      q_in[W] = pe[W][W] - pe[X][X] - pe[Y][Y] - pe[Z][Z];
      q_in[X] = pe[X][W] + pe[W][X] + pe[Y][Z] - pe[Z][Y];
      q_in[Y] = pe[W][Y] - pe[X][Z] + pe[Y][W] + pe[Z][X];
      q_in[Z] = pe[W][Z] + pe[X][Y] - pe[Y][X] + pe[Z][W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff <= op_in;
         bv_ff <= bv_in;
         m_ff  <= m_in;
         q_ff  <= q_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_op    = op_ff;
   assign out_bv    = bv_ff;
   assign out_m     = m_ff;
   assign out_q     = q_ff;

endmodule

// ----- hw/rtl/qrm_apply.sv -----
module qrm_apply #(
   parameter int DATA_WIDTH = qrm_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = qrm_pkg::FRAC_BITS_DEF,
   localparam int WM = qrm_pkg::m_width(DATA_WIDTH, FRAC_BITS),
   localparam int WQ = 2 * DATA_WIDTH + 2,
   localparam int WA = qrm_pkg::a_width(DATA_WIDTH, FRAC_BITS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  qrm_pkg::op_type              in_op,
   input  logic signed [DATA_WIDTH-1:0] in_bv [3],
   input  logic signed [WM-1:0]         in_m [3][3],
   input  logic signed [WQ-1:0]         in_q [4],
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [WA-1:0]         out_acc [4]
);

   localparam int D  = DATA_WIDTH;
   localparam int WL = 2 * D + 1;

   // First stage: each matrix entry times a vector component, split into a
   // low unsigned slice and a signed high slice to keep the multipliers narrow.
   logic                 pp_valid_ff, pp_valid_in;
   logic                 pp_ready, pp_load;
   qrm_pkg::op_type      op_ff, op_in;
   logic signed [WL-1:0] pl_ff [3][3];
   logic signed [WL-1:0] pl_in [3][3];
   logic signed [WM-1:0] ph_ff [3][3];
   logic signed [WM-1:0] ph_in [3][3];
   logic signed [WQ-1:0] q_ff [4];
   logic signed [WQ-1:0] q_in [4];

   // Second stage: recombined sums.
   logic                 acc_valid_ff, acc_valid_in;
   logic                 acc_load;
   logic signed [WA-1:0] acc_ff [4];
   logic signed [WA-1:0] acc_in [4];

   assign pp_ready    = !acc_valid_ff || out_ready;
   assign in_ready    = !pp_valid_ff || pp_ready;
   assign pp_load     = in_valid && in_ready;
   assign pp_valid_in = in_ready ? in_valid : pp_valid_ff;

   always_comb begin
      op_in = in_op;
      q_in  = in_q;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            pl_in[r][c] = signed'({1'b0, in_m[r][c][D-1:0]}) * in_bv[c];
            ph_in[r][c] = signed'(in_m[r][c][WM-1:D]) * in_bv[c];
         end
      end
   end

   assign acc_load     = pp_valid_ff && pp_ready;
   assign acc_valid_in = pp_ready ? pp_valid_ff : acc_valid_ff;

   always_comb begin
      if (op_ff == qrm_pkg::OP_ROTATE) begin
         for (int r = 0; r < 3; r++) begin
            acc_in[r] = '0;
            for (int c = 0; c < 3; c++) begin
               acc_in[r] = acc_in[r] + (WA'(ph_ff[r][c]) <<< D) + WA'(pl_ff[r][c]);
            end
         end
         acc_in[qrm_pkg::IDX_W] = '0;
      end else begin
         for (int k = 0; k < 4; k++) begin
            acc_in[k] = WA'(q_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_valid_ff  <= 1'b0;
         acc_valid_ff <= 1'b0;
      end else begin
         pp_valid_ff  <= pp_valid_in;
         acc_valid_ff <= acc_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pp_load) begin
         op_ff <= op_in;
         pl_ff <= pl_in;
         ph_ff <= ph_in;
         q_ff  <= q_in;
      end
      if (acc_load) begin
         acc_ff <= acc_in;
      end
   end

   assign out_valid = acc_valid_ff;
   assign out_acc   = acc_ff;

endmodule

// ----- hw/rtl/qrm_round.sv -----
module qrm_round #(
   parameter int DATA_WIDTH = qrm_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = qrm_pkg::FRAC_BITS_DEF,
   localparam int WA = qrm_pkg::a_width(DATA_WIDTH, FRAC_BITS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [WA-1:0]         in_acc [4],
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [DATA_WIDTH-1:0] out_res [4],
   output logic                         out_ovf
);

   localparam int WR = WA + 1;

   localparam logic signed [WR-1:0] HALF_R = WR'(1) << (FRAC_BITS - 1);
   localparam logic signed [WR-1:0] LIM_P  = (WR'(1) << (DATA_WIDTH - 1)) - WR'(1);
   localparam logic signed [WR-1:0] LIM_N  = -(WR'(1) << (DATA_WIDTH - 1));

   logic                         valid_ff, valid_in;
   logic                         load;
   logic signed [DATA_WIDTH-1:0] res_ff [4];
   logic signed [DATA_WIDTH-1:0] res_in [4];
   logic                         ovf_ff, ovf_in;
   logic signed [WR-1:0]         rnd [4];

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      ovf_in = 1'b0;
      for (int k = 0; k < 4; k++) begin
         rnd[k] = (WR'(in_acc[k]) + HALF_R) >>> FRAC_BITS;
         if (rnd[k] > LIM_P) begin
            res_in[k] = DATA_WIDTH'(LIM_P);
            ovf_in    = 1'b1;
         end else if (rnd[k] < LIM_N) begin
            res_in[k] = DATA_WIDTH'(LIM_N);
            ovf_in    = 1'b1;
         end else begin
            res_in[k] = DATA_WIDTH'(rnd[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
         ovf_ff <= ovf_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;
   assign out_ovf   = ovf_ff;

endmodule

// ----- hw/rtl/quaternion_rotate_and_multiply_core.sv -----
// Quaternion unit: Hamilton product a*b, or rotation of the vector part of b
// by a through the rotation matrix, in signed fixed point (Q2.14 by default).
// Requests arrive on the req_ stream: req_tuser selects the operation
// (0 product, 1 rotate) and req_tdata carries a_x, a_y, a_z, a_w, b_x, b_y,
// b_z, b_w. Each request gives exactly one result on the rsp_ stream:
// rsp_tdata carries res_x, res_y, res_z, res_w (res_w is zero for a
// rotation) and rsp_tuser is the saturation flag.
// The datapath is five register stages: component products, matrix terms
// and product sums, split partial products, recombination, then rounding
// and saturation into the output register. One request is accepted every
// cycle while rsp_tready is high. Each stage has its own valid bit and
// loads whenever it is empty or its successor moves, so when rsp_tready is
// low the bubbles still fill and up to five requests are held; nothing is
// dropped or repeated. Reset clears all valid bits; the pipeline is ready
// again in the first cycle after reset.
module quaternion_rotate_and_multiply_core #(
   parameter int DATA_WIDTH = qrm_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = qrm_pkg::FRAC_BITS_DEF,
   localparam int RSP_DATA_WIDTH = ((4 * DATA_WIDTH + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic                      req_tuser,  // req_type
   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w from the lowest bit up
   input  logic [8*DATA_WIDTH-1:0]   req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic                      rsp_tuser,  // overflow
   // res_x, res_y, res_z, res_w from the lowest bit up, zero padded
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   localparam int WM = qrm_pkg::m_width(DATA_WIDTH, FRAC_BITS);
   localparam int WQ = 2 * DATA_WIDTH + 2;
   localparam int WA = qrm_pkg::a_width(DATA_WIDTH, FRAC_BITS);

   qrm_pkg::op_type                req_op;
   logic signed [DATA_WIDTH-1:0]   req_a [4];
   logic signed [DATA_WIDTH-1:0]   req_b [4];

   logic                           mul_valid, mul_ready;
   qrm_pkg::op_type                mul_op;
   logic signed [DATA_WIDTH-1:0]   mul_bv [3];
   logic signed [2*DATA_WIDTH-1:0] mul_prod [4][4];

   logic                           mtx_valid, mtx_ready;
   qrm_pkg::op_type                mtx_op;
   logic signed [DATA_WIDTH-1:0]   mtx_bv [3];
   logic signed [WM-1:0]           mtx_m [3][3];
   logic signed [WQ-1:0]           mtx_q [4];

   logic                           acc_valid, acc_ready;
   logic signed [WA-1:0]           acc [4];

   logic signed [DATA_WIDTH-1:0]   res [4];

   assign req_op = qrm_pkg::op_type'(req_tuser);

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         req_a[k] = req_tdata[k*DATA_WIDTH +: DATA_WIDTH];
         req_b[k] = req_tdata[(k+4)*DATA_WIDTH +: DATA_WIDTH];
      end
   end

   qrm_mul #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_mul (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_op    (req_op),
      .in_a     (req_a),
      .in_b     (req_b),
      .out_valid(mul_valid),
      .out_ready(mul_ready),
      .out_op   (mul_op),
      .out_bv   (mul_bv),
      .out_prod (mul_prod)
   );

   qrm_matrix #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_matrix (
      .clock    (clock),
      .reset    (reset),
      .in_valid (mul_valid),
      .in_ready (mul_ready),
      .in_op    (mul_op),
      .in_bv    (mul_bv),
      .in_prod  (mul_prod),
      .out_valid(mtx_valid),
      .out_ready(mtx_ready),
      .out_op   (mtx_op),
      .out_bv   (mtx_bv),
      .out_m    (mtx_m),
      .out_q    (mtx_q)
   );

   qrm_apply #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_apply (
      .clock    (clock),
      .reset    (reset),
      .in_valid (mtx_valid),
      .in_ready (mtx_ready),
      .in_op    (mtx_op),
      .in_bv    (mtx_bv),
      .in_m     (mtx_m),
      .in_q     (mtx_q),
      .out_valid(acc_valid),
      .out_ready(acc_ready),
      .out_acc  (acc)
   );

   qrm_round #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_round (
      .clock    (clock),
      .reset    (reset),
      .in_valid (acc_valid),
      .in_ready (acc_ready),
      .in_acc   (acc),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_res  (res),
      .out_ovf  (rsp_tuser)
   );

   generate
      if (RSP_DATA_WIDTH > 4 * DATA_WIDTH) begin : g_pad
         assign rsp_tdata = {{(RSP_DATA_WIDTH - 4 * DATA_WIDTH){1'b0}},
                             res[qrm_pkg::IDX_W], res[qrm_pkg::IDX_Z],
                             res[qrm_pkg::IDX_Y], res[qrm_pkg::IDX_X]};
      end else begin : g_nopad
         assign rsp_tdata = {res[qrm_pkg::IDX_W], res[qrm_pkg::IDX_Z],
                             res[qrm_pkg::IDX_Y], res[qrm_pkg::IDX_X]};
      end
   endgenerate

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

   localparam int DW    = qrm_pkg::DATA_WIDTH_DEF;
   localparam int FRAC  = qrm_pkg::FRAC_BITS_DEF;
   localparam int RSP_W = ((4 * DW + 7) / 8) * 8;

   localparam int     ONE_FX      = 1 << FRAC;
   localparam int     MAX_VAL     = (1 << (DW - 1)) - 1;
   localparam int     MIN_VAL     = -(1 << (DW - 1));
   localparam longint HALF_LSB    = 64'sd1 <<< (FRAC - 1);
   localparam longint QUARTER_LSB = 64'sd1 <<< (FRAC - 2);

   localparam int PIPE_LATENCY = 5;
   localparam int HOLD_LEN     = 60;
   localparam int RUN_LEN      = 20;
   localparam int DRAIN_LIMIT  = 20000;

   localparam int STYLE_UNIT = 0;
   localparam int STYLE_FULL = 1;
   localparam int STYLE_EDGE = 2;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH,
      IDLE_PRESSURE
   } idle_mode_type;

   typedef struct packed {
      qrm_pkg::op_type      op;
      logic [3:0][DW-1:0]   a;
      logic [3:0][DW-1:0]   b;
   } quat_request_type;

   typedef struct packed {
      logic [3:0][DW-1:0]   res;
      logic                 ovf;
   } quat_result_type;

   typedef struct {
      quat_request_type req;
      bit               typed;
      quat_result_type  want;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic               req_tuser = 1'b0;   // req_type
   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w from the lowest bit up
   logic [8*DW-1:0]    req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic               rsp_tuser;          // overflow
   // res_x, res_y, res_z, res_w from the lowest bit up
   logic [RSP_W-1:0]   rsp_tdata;

   idle_mode_type      idle_mode = IDLE_NONE;
   quat_result_type    quat_results_due [$];
   directed_row_type   directed_rows [$];
   string              comp_name [4] = '{"res_x", "res_y", "res_z", "res_w"};

   int product_count   = 0;
   int rotate_count    = 0;
   int checked_count   = 0;
   int saturated_count = 0;
   int error_count     = 0;
   int hold_count      = 0;

   quaternion_rotate_and_multiply_core #(
      .DATA_WIDTH(DW),
      .FRAC_BITS (FRAC)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata)
   );

   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // A doubled product 2*p*q, rounded back to the fraction width.
   function automatic longint doubled_term(input longint p, input longint q);
      return (p * q + QUARTER_LSB) >>> (FRAC - 1);
   endfunction

   function automatic quat_result_type predict_quat_result(input quat_request_type r);
      longint ax, ay, az, aw, bx, by, bz, bw;
      longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
      longint acc [4];
      longint v;
      quat_result_type q;
      ax = $signed(r.a[qrm_pkg::IDX_X]);
      ay = $signed(r.a[qrm_pkg::IDX_Y]);
      az = $signed(r.a[qrm_pkg::IDX_Z]);
      aw = $signed(r.a[qrm_pkg::IDX_W]);
      bx = $signed(r.b[qrm_pkg::IDX_X]);
      by = $signed(r.b[qrm_pkg::IDX_Y]);
      bz = $signed(r.b[qrm_pkg::IDX_Z]);
      bw = $signed(r.b[qrm_pkg::IDX_W]);
      if (r.op == qrm_pkg::OP_PRODUCT) begin
         acc[qrm_pkg::IDX_W] = aw * bw - ax * bx - ay * by - az * bz;
         acc[qrm_pkg::IDX_X] = ax * bw + aw * bx + ay * bz - az * by;
         acc[qrm_pkg::IDX_Y] = aw * by - ax * bz + ay * bw + az * bx;
         acc[qrm_pkg::IDX_Z] = aw * bz + ax * by - ay * bx + az * bw;
      end else begin
         xx = doubled_term(ax, ax);
         yy = doubled_term(ay, ay);
         zz = doubled_term(az, az);
         xy = doubled_term(ax, ay);
         xz = doubled_term(ax, az);
         yz = doubled_term(ay, az);
         wx = doubled_term(aw, ax);
         wy = doubled_term(aw, ay);
         wz = doubled_term(aw, az);
         acc[qrm_pkg::IDX_X] = (ONE_FX - (yy + zz)) * bx + (xy - wz) * by + (xz + wy) * bz;
         acc[qrm_pkg::IDX_Y] = (xy + wz) * bx + (ONE_FX - (xx + zz)) * by + (yz - wx) * bz;
         acc[qrm_pkg::IDX_Z] = (xz - wy) * bx + (yz + wx) * by + (ONE_FX - (xx + yy)) * bz;
         // The scalar of a rotated vector is zero, which never saturates.
         acc[qrm_pkg::IDX_W] = 0;
      end
      q.ovf = 1'b0;
      for (int i = 0; i < 4; i++) begin
         v = (acc[i] + HALF_LSB) >>> FRAC;
         if (v > MAX_VAL) begin
            v = MAX_VAL;
            q.ovf = 1'b1;
         end else if (v < MIN_VAL) begin
            v = MIN_VAL;
            q.ovf = 1'b1;
         end
         q.res[i] = v[DW-1:0];
      end
      return q;
   endfunction

   task automatic add_row(input qrm_pkg::op_type op,
                          input int ax, input int ay, input int az, input int aw,
                          input int bx, input int by, input int bz, input int bw,
                          input bit typed,
                          input int ex, input int ey, input int ez, input int ew,
                          input bit eovf);
      directed_row_type row;
      row.req.op = op;
      row.req.a[qrm_pkg::IDX_X] = DW'(ax);
      row.req.a[qrm_pkg::IDX_Y] = DW'(ay);
      row.req.a[qrm_pkg::IDX_Z] = DW'(az);
      row.req.a[qrm_pkg::IDX_W] = DW'(aw);
      row.req.b[qrm_pkg::IDX_X] = DW'(bx);
      row.req.b[qrm_pkg::IDX_Y] = DW'(by);
      row.req.b[qrm_pkg::IDX_Z] = DW'(bz);
      row.req.b[qrm_pkg::IDX_W] = DW'(bw);
      row.typed = typed;
      row.want.res[qrm_pkg::IDX_X] = DW'(ex);
      row.want.res[qrm_pkg::IDX_Y] = DW'(ey);
      row.want.res[qrm_pkg::IDX_Z] = DW'(ez);
      row.want.res[qrm_pkg::IDX_W] = DW'(ew);
      row.want.ovf = eovf;
      directed_rows.push_back(row);
   endtask

   function automatic logic [DW-1:0] random_component(input int style);
      logic [31:0] raw;
      int pick;
      raw  = $urandom;
      pick = $urandom_range(7);
      case (style)
         STYLE_UNIT: return DW'(int'($urandom_range(2 * ONE_FX)) - ONE_FX);
         STYLE_FULL: return raw[DW-1:0];
         default: begin
            case (pick)
               0: return DW'(MIN_VAL);
               1: return DW'(MAX_VAL);
               2: return DW'(-1);
               3: return DW'(0);
               4: return DW'(1);
               5: return DW'(ONE_FX);
               6: return DW'(-ONE_FX);
               default: return DW'(MIN_VAL + 1);
            endcase
         end
      endcase
   endfunction

   // Half the requests have components of at most unit size, where real traffic
   // sits; the rest are full-range or mixed corner values that drive saturation.
   function automatic quat_request_type random_request();
      quat_request_type r;
      int choice;
      int style;
      choice = $urandom_range(9);
      style  = (choice < 5) ? STYLE_UNIT : (choice < 8) ? STYLE_FULL : -1;
      r.op = qrm_pkg::op_type'($urandom_range(1));
      for (int i = 0; i < 4; i++) begin
         r.a[i] = random_component((style < 0) ? int'($urandom_range(2)) : style);
         r.b[i] = random_component((style < 0) ? int'($urandom_range(2)) : style);
      end
      return r;
   endfunction

   function automatic int sender_idle_pct(input idle_mode_type m);
      return (m == IDLE_SENDER) ? 86 : (m == IDLE_BOTH) ? 10 : 0;
   endfunction

   function automatic int receiver_stall_pct(input idle_mode_type m);
      return (m == IDLE_RECEIVER) ? 86 : (m == IDLE_BOTH) ? 10 : 0;
   endfunction

   task automatic send_request(input quat_request_type r, input quat_result_type due);
      while ($urandom_range(99) < sender_idle_pct(idle_mode)) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= r.op;
      req_tdata  <= {r.b, r.a};
      do @(posedge clock); while (!req_tready);
      quat_results_due.push_back(due);
      if (r.op == qrm_pkg::OP_PRODUCT)
         product_count++;
      else
         rotate_count++;
   endtask

   // Receiver readiness. Under pressure it holds off for a long stretch so
   // that the pipeline fills and the request side has to stall.
   always @(negedge clock) begin
      if (idle_mode == IDLE_PRESSURE) begin
         rsp_tready <= (hold_count >= HOLD_LEN);
         hold_count = (hold_count == HOLD_LEN + RUN_LEN - 1) ? 0 : hold_count + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct(idle_mode));
         hold_count = 0;
      end
   end

   always @(posedge clock) begin
      quat_result_type got;
      quat_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.res = rsp_tdata[4*DW-1:0];
         got.ovf = rsp_tuser;
         if (quat_results_due.size() == 0) begin
            $error("result arrived with no request outstanding");
            error_count++;
         end else begin
            want = quat_results_due.pop_front();
            checked_count++;
            if (got.ovf)
               saturated_count++;
            for (int i = 0; i < 4; i++) begin
               if (got.res[i] !== want.res[i]) begin
                  $error("%s expected %0d actual %0d", comp_name[i],
                         $signed(want.res[i]), $signed(got.res[i]));
                  error_count++;
               end
            end
            if (got.ovf !== want.ovf) begin
               $error("overflow expected %0d actual %0d", want.ovf, got.ovf);
               error_count++;
            end
         end
      end
   end

   initial begin
      idle_mode_type    phase_mode [5];
      int               phase_len  [5];
      quat_result_type  due;
      quat_request_type r;
      int               waited;

      phase_mode = '{IDLE_PRESSURE, IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
      phase_len  = '{200, 400, 250, 250, 500};

      //       op                   a_x  a_y  a_z  a_w  b_x  b_y  b_z  b_w
      add_row(qrm_pkg::OP_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
      add_row(qrm_pkg::OP_ROTATE,  0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
      add_row(qrm_pkg::OP_PRODUCT, 0, 0, 0, ONE_FX, 100, -200, 300, -400,
              1, 100, -200, 300, -400, 0);
      // Identity rotation leaves the vector alone and ignores b_w.
      add_row(qrm_pkg::OP_ROTATE,  0, 0, 0, ONE_FX, 100, -200, 300, 12345,
              1, 100, -200, 300, 0, 0);
      add_row(qrm_pkg::OP_PRODUCT, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL,
              MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL,
              1, MAX_VAL, MAX_VAL, MAX_VAL, MIN_VAL, 1);
      // i * j = k.
      add_row(qrm_pkg::OP_PRODUCT, ONE_FX, 0, 0, 0, 0, ONE_FX, 0, 0,
              1, 0, 0, ONE_FX, 0, 0);
      // Rounding ties go toward plus infinity on both signs.
      add_row(qrm_pkg::OP_PRODUCT, 0, 0, 0, 1, 0, 0, 0, ONE_FX / 2, 1, 0, 0, 0, 1, 0);
      add_row(qrm_pkg::OP_PRODUCT, 0, 0, 0, -1, 0, 0, 0, ONE_FX / 2, 1, 0, 0, 0, 0, 0);
      add_row(qrm_pkg::OP_PRODUCT, MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL,
              MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL, 0, 0, 0, 0, 0, 0);
      add_row(qrm_pkg::OP_ROTATE,  MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL,
              MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL, 0, 0, 0, 0, 0, 0);
      add_row(qrm_pkg::OP_ROTATE,  MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL,
              MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL, 0, 0, 0, 0, 0, 0);
      add_row(qrm_pkg::OP_ROTATE,  MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL,
              MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL, 0, 0, 0, 0, 0, 0);
      add_row(qrm_pkg::OP_ROTATE,  0, 0, 11585, 11585, ONE_FX, 0, 0, 0,
              0, 0, 0, 0, 0, 0);
      add_row(qrm_pkg::OP_ROTATE,  MAX_VAL, 0, 0, 0, 0, MAX_VAL, 0, 0,
              0, 0, 0, 0, 0, 0);
      add_row(qrm_pkg::OP_ROTATE,  MIN_VAL, 0, 0, MAX_VAL, MAX_VAL, MIN_VAL, MAX_VAL, 0,
              0, 0, 0, 0, 0, 0);
      add_row(qrm_pkg::OP_PRODUCT, 'h5555, 'h5555, 'h5555, 'h5555,
              'hAAAA, 'hAAAA, 'hAAAA, 'hAAAA, 0, 0, 0, 0, 0, 0);
      add_row(qrm_pkg::OP_ROTATE,  'hAAAA, 'h5555, 'hAAAA, 'h5555,
              'h5555, 'hAAAA, 'h5555, 'hAAAA, 0, 0, 0, 0, 0, 0);
      add_row(qrm_pkg::OP_PRODUCT, -1, -1, -1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0);
      add_row(qrm_pkg::OP_ROTATE,  -1, -1, -1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0);
      add_row(qrm_pkg::OP_PRODUCT, MAX_VAL, MIN_VAL, MAX_VAL, MIN_VAL,
              MIN_VAL, MAX_VAL, MIN_VAL, MAX_VAL, 0, 0, 0, 0, 0, 0);
      add_row(qrm_pkg::OP_ROTATE,  MAX_VAL, MIN_VAL, MAX_VAL, MIN_VAL,
              MIN_VAL, MAX_VAL, MIN_VAL, MAX_VAL, 0, 0, 0, 0, 0, 0);

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n]) begin
         due = directed_rows[n].typed ? directed_rows[n].want
                                      : predict_quat_result(directed_rows[n].req);
         send_request(directed_rows[n].req, due);
      end

      for (int p = 0; p < 5; p++) begin
         idle_mode = phase_mode[p];
         for (int n = 0; n < phase_len[p]; n++) begin
            r = random_request();
            send_request(r, predict_quat_result(r));
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      idle_mode = IDLE_NONE;

      waited = 0;
      while (quat_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (quat_results_due.size() != 0) begin
         $error("%0d results never arrived", quat_results_due.size());
         error_count++;
      end

      $display("Sent %0d products and %0d rotations under five handshake patterns,",
               product_count, rotate_count);
      $display("checked %0d results, %0d of them saturated.",
               checked_count, saturated_count);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- quaternion_rotate_and_multiply_core.f -----
hw/rtl/qrm_pkg.sv
hw/rtl/qrm_mul.sv
hw/rtl/qrm_matrix.sv
hw/rtl/qrm_apply.sv
hw/rtl/qrm_round.sv
hw/rtl/quaternion_rotate_and_multiply_core.sv
verif/tb.sv
